/* rtl/tlpb_pkg.sv */
// Package with the types and constants shared by the two-layer pixel blend unit.
`default_nettype none

package tlpb_pkg;

    // Blend mode codes held in the configuration register.
    localparam logic [2:0] MODE_MULTIPLY = 3'd0;
    localparam logic [2:0] MODE_SCREEN   = 3'd1;
    localparam logic [2:0] MODE_SUBTRACT = 3'd2;
    localparam logic [2:0] MODE_ADD      = 3'd3;
    localparam logic [2:0] MODE_OVERLAY  = 3'd4;

    localparam int unsigned CH_W       = 8;
    localparam int unsigned MODE_W     = 3;
    localparam int unsigned PROD_W     = 17;
    localparam int unsigned SUM_W      = 18;
    localparam int unsigned QUOT_W     = 9;
    localparam logic [7:0]  CH_MAX     = 8'd255;
    localparam logic [17:0] ROUND_BIAS = 18'd127;

    // Per-channel flags that travel down the pipeline.
    typedef struct packed {
        logic       inv;     // result is 255 minus the rounded quotient
        logic       direct;  // result is taken from dres, no product needed
        logic [7:0] dres;    // direct result (subtract, add, pass-through)
    } t_ch_ctrl;

    // Stage 1: multiplier operands.
    typedef struct packed {
        logic [7:0] op_a;
        logic [7:0] op_b;
        logic       dbl;
        t_ch_ctrl   ctrl;
    } t_ch_prep;

    // Stage 2: product, doubled for overlay.
    typedef struct packed {
        logic [16:0] prod;
        t_ch_ctrl    ctrl;
    } t_ch_prod;

    // Stage 3: rounded dividend and estimated quotient.
    typedef struct packed {
        logic [17:0] dividend;
        logic [8:0]  est;
        t_ch_ctrl    ctrl;
    } t_ch_quot;

endpackage

`default_nettype wire

/* rtl/tlpb_if.sv */
// Stream interfaces for the pixel pair input and the blended pixel output.
`default_nettype none

interface tlpb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] top_blue;
    logic [7:0] top_green;
    logic [7:0] top_red;
    logic [7:0] bottom_blue;
    logic [7:0] bottom_green;
    logic [7:0] bottom_red;

    modport source (
        output valid, top_blue, top_green, top_red, bottom_blue, bottom_green, bottom_red,
        input  ready
    );
    modport sink (
        input  valid, top_blue, top_green, top_red, bottom_blue, bottom_green, bottom_red,
        output ready
    );
endinterface

interface tlpb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;

    modport source (
        output valid, out_blue, out_green, out_red,
        input  ready
    );
    modport sink (
        input  valid, out_blue, out_green, out_red,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/tlpb_prep.sv */
// First pipeline stage for one channel: mode decode, operand selection and the direct modes.
`default_nettype none

module tlpb_prep (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic [2:0]           i_mode,
    input  wire logic [7:0]           i_top,
    input  wire logic [7:0]           i_bottom,
    output tlpb_pkg::t_ch_prep        o_prep
);

    tlpb_pkg::t_ch_prep r_prep;
    tlpb_pkg::t_ch_prep n_prep;
    logic [7:0]         w_diff;
    logic [8:0]         w_sum;

    // Saturating difference and full 9-bit sum of the two channels.
    assign w_diff = (i_top > i_bottom) ? (i_top - i_bottom) : 8'd0;
    assign w_sum  = {1'b0, i_top} + {1'b0, i_bottom};

    // Operands for the product path; 255 - x is the complement of an 8-bit x.
    always_comb begin
        n_prep.op_a        = i_top;
        n_prep.op_b        = i_bottom;
        n_prep.dbl         = 1'b0;
        n_prep.ctrl.inv    = 1'b0;
        n_prep.ctrl.direct = 1'b0;
        n_prep.ctrl.dres   = i_top;
        unique case (i_mode)
            tlpb_pkg::MODE_MULTIPLY: begin
                n_prep.ctrl.direct = 1'b0;
            end
            tlpb_pkg::MODE_SCREEN: begin
                n_prep.op_a     = ~i_top;
                n_prep.op_b     = ~i_bottom;
                n_prep.ctrl.inv = 1'b1;
            end
            tlpb_pkg::MODE_SUBTRACT: begin
                n_prep.ctrl.direct = 1'b1;
                n_prep.ctrl.dres   = w_diff;
            end
            tlpb_pkg::MODE_ADD: begin
                n_prep.ctrl.direct = 1'b1;
                n_prep.ctrl.dres   = w_sum[8] ? tlpb_pkg::CH_MAX : w_sum[7:0];
            end
            tlpb_pkg::MODE_OVERLAY: begin
                n_prep.dbl = 1'b1;
                if (i_bottom[7]) begin
                    n_prep.op_a     = ~i_top;
                    n_prep.op_b     = ~i_bottom;
                    n_prep.ctrl.inv = 1'b1;
                end
            end
            default: begin
                // Unused codes pass the top pixel through.
                n_prep.ctrl.direct = 1'b1;
                n_prep.ctrl.dres   = i_top;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prep <= n_prep;
        end
    end

    assign o_prep = r_prep;

endmodule

`default_nettype wire

/* rtl/tlpb_mul.sv */
// Second pipeline stage for one channel: the 8 by 8 product, doubled for overlay.
`default_nettype none

module tlpb_mul (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire tlpb_pkg::t_ch_prep i_prep,
    output tlpb_pkg::t_ch_prod      o_prod
);

    tlpb_pkg::t_ch_prod r_prod;
    tlpb_pkg::t_ch_prod n_prod;
    logic [15:0]        w_mult;

    assign w_mult = 16'(i_prep.op_a) * 16'(i_prep.op_b);

    // Doubling is a one-place shift.
    always_comb begin
        n_prod.prod = i_prep.dbl ? {w_mult, 1'b0} : {1'b0, w_mult};
        n_prod.ctrl = i_prep.ctrl;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

/* rtl/tlpb_quot.sv */
// Third pipeline stage for one channel: rounding bias and a quotient estimate for division by 255.
`default_nettype none

module tlpb_quot (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire tlpb_pkg::t_ch_prod i_prod,
    output tlpb_pkg::t_ch_quot      o_quot
);

    tlpb_pkg::t_ch_quot r_quot;
    tlpb_pkg::t_ch_quot n_quot;
    logic [17:0]        w_dividend;
    logic [18:0]        w_scaled;

    // x/255 is close to (x + x/256)/256; the estimate is the true quotient or one below it.
    assign w_dividend = 18'(i_prod.prod) + tlpb_pkg::ROUND_BIAS;
    assign w_scaled   = 19'(w_dividend) + 19'(w_dividend >> 8);

    always_comb begin
        n_quot.dividend = w_dividend;
        n_quot.est      = w_scaled[16:8];
        n_quot.ctrl     = i_prod.ctrl;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quot <= n_quot;
        end
    end

    assign o_quot = r_quot;

endmodule

`default_nettype wire

/* rtl/tlpb_fin.sv */
// Last pipeline stage for one channel: quotient correction, inversion and result selection.
`default_nettype none

module tlpb_fin (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire tlpb_pkg::t_ch_quot i_quot,
    output logic [7:0]              o_res
);

    logic [7:0]  r_res;
    logic [7:0]  n_res;
    logic [17:0] w_times;
    logic [17:0] w_rem;
    logic        w_corr;
    logic [8:0]  w_q;
    logic [7:0]  w_blend;

    // The remainder left by the estimate is below 510, so one step corrects it.
    assign w_times = 18'({i_quot.est, 8'h00}) - 18'(i_quot.est);
    assign w_rem   = i_quot.dividend - w_times;
    assign w_corr  = (w_rem >= 18'(tlpb_pkg::CH_MAX));
    assign w_q     = i_quot.est + 9'(w_corr);

    // Screen and the upper half of overlay subtract from full scale.
    assign w_blend = i_quot.ctrl.inv ? (tlpb_pkg::CH_MAX - w_q[7:0]) : w_q[7:0];
    assign n_res   = i_quot.ctrl.direct ? i_quot.ctrl.dres : w_blend;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

/* rtl/two_layer_pixel_blend_unit.sv */
// Top level of the two-layer pixel blend unit: mode register, pipeline control and channel lanes.
`default_nettype none

// Blends one top and one bottom pixel (8-bit blue, green and red) per transaction in the mode
// held by the 3-bit register written through i_cfg_we and i_cfg_wdata: 0 multiply, 1 screen,
// 2 saturating subtract, 3 saturating add, 4 overlay; other codes pass the top pixel through.
// Division by 255 is rounded to nearest. The pipeline has four register stages (operand
// selection, product, quotient estimate, correction and output), and one transaction is
// taken every cycle while the output is not stalled. Stall is handled per stage, so an
// empty stage is refilled even while the output waits. Write the mode only while no
// transaction is in flight.
module two_layer_pixel_blend_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_wdata,
    tlpb_in_if.sink         i_pix,
    tlpb_out_if.source      o_pix
);

    localparam int unsigned NUM_CH = 3;

    logic [2:0]         r_mode;
    logic               r_v1;
    logic               r_v2;
    logic               r_v3;
    logic               r_v4;
    logic               w_en1;
    logic               w_en2;
    logic               w_en3;
    logic               w_en4;
    logic [7:0]         w_top    [NUM_CH];
    logic [7:0]         w_bottom [NUM_CH];
    logic [7:0]         w_res    [NUM_CH];
    tlpb_pkg::t_ch_prep w_prep   [NUM_CH];
    tlpb_pkg::t_ch_prod w_prod   [NUM_CH];
    tlpb_pkg::t_ch_quot w_quot   [NUM_CH];

    // Mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= tlpb_pkg::MODE_MULTIPLY;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // A stage loads when it is empty or its contents move on.
    assign w_en4       = !r_v4 || o_pix.ready;
    assign w_en3       = !r_v3 || w_en4;
    assign w_en2       = !r_v2 || w_en3;
    assign w_en1       = !r_v1 || w_en2;
    assign i_pix.ready = w_en1;

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_pix.valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Channel order is blue, green, red.
    assign w_top[0]    = i_pix.top_blue;
    assign w_top[1]    = i_pix.top_green;
    assign w_top[2]    = i_pix.top_red;
    assign w_bottom[0] = i_pix.bottom_blue;
    assign w_bottom[1] = i_pix.bottom_green;
    assign w_bottom[2] = i_pix.bottom_red;

    // One lane of four stages for each channel.
    for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
        tlpb_prep u_prep (
            .i_clk    (i_clk),
            .i_en     (w_en1),
            .i_mode   (r_mode),
            .i_top    (w_top[g]),
            .i_bottom (w_bottom[g]),
            .o_prep   (w_prep[g])
        );

        tlpb_mul u_mul (
            .i_clk  (i_clk),
            .i_en   (w_en2),
            .i_prep (w_prep[g]),
            .o_prod (w_prod[g])
        );

        tlpb_quot u_quot (
            .i_clk  (i_clk),
            .i_en   (w_en3),
            .i_prod (w_prod[g]),
            .o_quot (w_quot[g])
        );

        tlpb_fin u_fin (
            .i_clk  (i_clk),
            .i_en   (w_en4),
            .i_quot (w_quot[g]),
            .o_res  (w_res[g])
        );
    end

    assign o_pix.valid     = r_v4;
    assign o_pix.out_blue  = w_res[0];
    assign o_pix.out_green = w_res[1];
    assign o_pix.out_red   = w_res[2];

endmodule

`default_nettype wire

/* dv/tlpb_blend_checker.sv */
// Checker that predicts each blended pixel from the accepted pixel pairs and compares the results.
`default_nettype none

module tlpb_blend_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_wdata,
    tlpb_in_if              i_pix,
    tlpb_out_if             i_res,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LANE_MAX    = 255;
    localparam int unsigned ROUND_HALF  = 127;
    localparam int unsigned OVERLAY_KNEE = 127;
    localparam int          MAX_REPORTS = 10;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_blended_px;

    // Blended pixels still owed by the block, oldest first.
    t_blended_px blended_q[$];
    logic [2:0]  mode_q;
    int          fail_count;
    int          checked;

    // Division by 255, rounded to nearest.
    function automatic int unsigned div255_round(input int unsigned x);
        return (x + ROUND_HALF) / LANE_MAX;
    endfunction

    // One colour channel blended in the given mode.
    function automatic logic [7:0] blend_lane(input logic [2:0] mode, input logic [7:0] top_v,
                                              input logic [7:0] bot_v);
        int unsigned t;
        int unsigned b;
        int unsigned res;
        t = top_v;
        b = bot_v;
        case (mode)
            tlpb_pkg::MODE_MULTIPLY: begin
                res = div255_round(t * b);
            end
            tlpb_pkg::MODE_SCREEN: begin
                res = LANE_MAX - div255_round((LANE_MAX - t) * (LANE_MAX - b));
            end
            tlpb_pkg::MODE_SUBTRACT: begin
                res = (t > b) ? t - b : 0;
            end
            tlpb_pkg::MODE_ADD: begin
                res = (t + b > LANE_MAX) ? LANE_MAX : t + b;
            end
            tlpb_pkg::MODE_OVERLAY: begin
                if (b <= OVERLAY_KNEE) begin
                    res = div255_round(2 * t * b);
                end else begin
                    res = LANE_MAX - div255_round(2 * (LANE_MAX - t) * (LANE_MAX - b));
                end
            end
            // Unused codes pass the top pixel through.
            default: begin
                res = t;
            end
        endcase
        return res[7:0];
    endfunction

    task automatic log_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    // Follow the mode register and both channels at every rising edge.
    always @(posedge i_clk) begin : monitor
        t_blended_px want;
        t_blended_px got;
        if (!i_rst_n) begin
            mode_q = tlpb_pkg::MODE_MULTIPLY;
            blended_q.delete();
        end else begin
            // Output transaction: compare with the oldest prediction.
            if (i_res.valid && i_res.ready) begin
                got = '{mode_q, i_res.out_blue, i_res.out_green, i_res.out_red};
                if (blended_q.size() == 0) begin
                    log_failure($sformatf("Unexpected result b/g/r %0d/%0d/%0d",
                                          got.blue, got.green, got.red));
                end else begin
                    want = blended_q.pop_front();
                    checked++;
                    if (got.blue !== want.blue || got.green !== want.green ||
                        got.red !== want.red) begin
                        log_failure($sformatf(
                            "Mismatch in mode %0d: expected b/g/r %0d/%0d/%0d, got %0d/%0d/%0d",
                            want.mode, want.blue, want.green, want.red,
                            got.blue, got.green, got.red));
                    end
                end
            end
            // Input transaction: predict its blended pixel in the current mode.
            if (i_pix.valid && i_pix.ready) begin
                want.mode  = mode_q;
                want.blue  = blend_lane(mode_q, i_pix.top_blue, i_pix.bottom_blue);
                want.green = blend_lane(mode_q, i_pix.top_green, i_pix.bottom_green);
                want.red   = blend_lane(mode_q, i_pix.top_red, i_pix.bottom_red);
                blended_q  = {blended_q, want};
            end
            if (i_cfg_we) begin
                mode_q = i_cfg_wdata;
            end
        end
        o_pending    = blended_q.size();
        o_fail_count = fail_count;
        o_checked    = checked;
    end

    initial begin
        fail_count   = 0;
        checked      = 0;
        mode_q       = tlpb_pkg::MODE_MULTIPLY;
        o_pending    = 0;
        o_fail_count = 0;
        o_checked    = 0;
    end

endmodule

`default_nettype wire

/* dv/two_layer_pixel_blend_unit_tb.sv */
// Testbench top for the two-layer pixel blend unit: clock, reset, stimulus and verdict.
`default_nettype none

module two_layer_pixel_blend_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 11;
    localparam int PIPE_DEPTH      = 4;
    localparam int ITEMS_PER_PHASE = 90;
    localparam int HOLD_PHASE      = 6;
    localparam int HOLD_CYCLES     = 80;
    localparam int CYCLE_LIMIT     = 400000;

    // Codes with no blend of their own; the block passes the top pixel through.
    localparam logic [2:0] MODE_UNUSED_5 = 3'd5;
    localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
    localparam logic [2:0] MODE_UNUSED_7 = 3'd7;

    localparam logic [2:0] ALL_MODES [8] = '{
        tlpb_pkg::MODE_MULTIPLY, tlpb_pkg::MODE_SCREEN, tlpb_pkg::MODE_SUBTRACT,
        tlpb_pkg::MODE_ADD, tlpb_pkg::MODE_OVERLAY, MODE_UNUSED_5, MODE_UNUSED_6,
        MODE_UNUSED_7
    };
    localparam logic [2:0] RAND_MODES [11] = '{
        tlpb_pkg::MODE_OVERLAY, tlpb_pkg::MODE_MULTIPLY, tlpb_pkg::MODE_SCREEN,
        tlpb_pkg::MODE_SUBTRACT, tlpb_pkg::MODE_ADD, MODE_UNUSED_7,
        tlpb_pkg::MODE_OVERLAY, MODE_UNUSED_5, tlpb_pkg::MODE_SCREEN, MODE_UNUSED_6,
        tlpb_pkg::MODE_ADD
    };

    typedef struct packed {
        logic [7:0] top_blue;
        logic [7:0] top_green;
        logic [7:0] top_red;
        logic [7:0] bottom_blue;
        logic [7:0] bottom_green;
        logic [7:0] bottom_red;
    } t_pixel_pair;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [2:0] i_cfg_wdata;
    int         fail_count;
    int         pending;
    int         checked;
    int         phase_idx = -1;
    int         sent = 0;
    int         cycle_count;

    tlpb_in_if  pix_in ();
    tlpb_out_if pix_out ();

    two_layer_pixel_blend_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix       (pix_in),
        .o_pix       (pix_out)
    );

    tlpb_blend_checker u_blend_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_pix        (pix_in),
        .i_res        (pix_out),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Mostly back to back, sometimes a short pause, now and then a long one.
    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            return 0;
        end else if (pick < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Channel value with a bias towards the range ends and the overlay knee.
    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 15))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd127;
            3: return 8'd128;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_pixel_pair rand_pair();
        t_pixel_pair p;
        p.top_blue     = rand_chan();
        p.top_green    = rand_chan();
        p.top_red      = rand_chan();
        p.bottom_blue  = rand_chan();
        p.bottom_green = rand_chan();
        p.bottom_red   = rand_chan();
        // Equal layers sit on the edge of the subtract clamp.
        if ($urandom_range(0, 9) == 0) begin
            p.bottom_blue = p.top_blue;
        end
        // Complementary layers sum to exactly full scale.
        if ($urandom_range(0, 9) == 0) begin
            p.bottom_green = ~p.top_green;
        end
        if ($urandom_range(0, 9) == 0) begin
            p.bottom_red = p.top_red;
        end
        return p;
    endfunction

    // Corner pixels: all-zero and all-full layers, the overlay knee on both sides,
    // equal layers for subtract and the add limit reached exactly and just passed.
    function automatic t_pixel_pair directed_pair(input int idx);
        case (idx)
            0:       return '{8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255};
            1:       return '{8'd255, 8'd200, 8'd200, 8'd0, 8'd127, 8'd128};
            default: return '{8'd100, 8'd128, 8'd128, 8'd100, 8'd127, 8'd128};
        endcase
    endfunction

    // Offer one pixel pair after an optional gap and hold it until accepted.
    task automatic send_pair(input t_pixel_pair p, input int gap);
        if (gap > 0) begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_in.valid        <= 1'b1;
        pix_in.top_blue     <= p.top_blue;
        pix_in.top_green    <= p.top_green;
        pix_in.top_red      <= p.top_red;
        pix_in.bottom_blue  <= p.bottom_blue;
        pix_in.bottom_green <= p.bottom_green;
        pix_in.bottom_red   <= p.bottom_red;
        do @(posedge i_clk); while (!pix_in.ready);
        sent++;
    endtask

    // Wait for every predicted pixel to come out, then let the pipeline settle.
    // The first falling edge lets the checker count the last accepted transaction.
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (PIPE_DEPTH) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic [2:0] mode);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Result receiver: random stalls, free-running stretches and one long hold.
    initial begin : receiver
        int stall_left;
        int free_left;
        int pick;
        bit hold_done;
        stall_left = 0;
        free_left  = 0;
        hold_done  = 1'b0;
        pix_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (phase_idx == HOLD_PHASE && !hold_done) begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                pix_out.ready <= 1'b0;
                stall_left--;
            end else if (free_left > 0) begin
                pix_out.ready <= 1'b1;
                free_left--;
            end else begin
                pix_out.ready <= 1'b1;
                pick = $urandom_range(0, 99);
                if (pick < 20) begin
                    stall_left = $urandom_range(1, 3);
                end else if (pick < 24) begin
                    stall_left = $urandom_range(8, 30);
                end else if (pick < 26) begin
                    free_left = $urandom_range(20, 60);
                end
            end
        end
    end

    // Stimulus: corner pixels in every mode code, then random phases.
    initial begin : stimulus
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_wdata         <= tlpb_pkg::MODE_MULTIPLY;
        pix_in.valid        <= 1'b0;
        pix_in.top_blue     <= 8'd0;
        pix_in.top_green    <= 8'd0;
        pix_in.top_red      <= 8'd0;
        pix_in.bottom_blue  <= 8'd0;
        pix_in.bottom_green <= 8'd0;
        pix_in.bottom_red   <= 8'd0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The first pass runs on the mode left by reset.
        foreach (ALL_MODES[m]) begin
            if (m != 0) begin
                wait_drained();
                set_mode(ALL_MODES[m]);
            end
            for (int k = 0; k < 3; k++) begin
                send_pair(directed_pair(k), pick_gap());
            end
            pix_in.valid <= 1'b0;
        end

        // Random phases; a block of items in each goes back to back.
        foreach (RAND_MODES[ph]) begin
            wait_drained();
            phase_idx = ph;
            set_mode(RAND_MODES[ph]);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                send_pair(rand_pair(), (k >= 20 && k < 40) ? 0 : pick_gap());
            end
            pix_in.valid <= 1'b0;
        end

        wait_drained();
        $display("Covered %0d pixel pairs over all eight mode codes, unused codes included.",
                 sent);
        $display("Stalls on both sides and one %0d-cycle output hold; %0d checked, %0d failed.",
                 HOLD_CYCLES, checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS two_layer_pixel_blend_unit");
        end else begin
            $display("FAIL two_layer_pixel_blend_unit");
        end
        $finish;
    end

    // Cycle counter that ends a run that hangs.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count, pending);
        $display("FAIL two_layer_pixel_blend_unit");
        $finish;
    end

endmodule

`default_nettype wire
